>>> rtl/sensor_packet_decoder_macros.svh
// assertion macros of the sensor packet decoder
`ifndef SENSOR_PACKET_DECODER_MACROS_SVH
`define SENSOR_PACKET_DECODER_MACROS_SVH

// same-cycle implication, disabled in reset
`define SPD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication, disabled in reset
`define SPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

>>> rtl/spd_pkg.sv
// types, constants and the crc helper of the sensor packet decoder
`default_nettype none

package spd_pkg;

    localparam logic [3:0] PktLen      = 4'd10;
    localparam logic [3:0] FieldDepth  = 4'd9;
    localparam logic [3:0] AckLen      = 4'd3;
    localparam logic [7:0] CrcPoly     = 8'h8C;
    localparam logic [9:0] TenFull     = 10'd1013;
    localparam logic [11:0] MvOffset   = 12'd387;
    localparam logic [14:0] RecipNine  = 15'd14564;  // ceil(2^17 / 9)
    localparam int         RecipShift  = 17;

    localparam logic [10:0] LimitReset = 11'd1891;
    localparam logic [9:0]  CapReset   = 10'd840;

    localparam logic [7:0] ChA = 8'h41;
    localparam logic [7:0] ChC = 8'h43;
    localparam logic [7:0] ChK = 8'h4B;

    // result kinds
    localparam logic [1:0] KindAck    = 2'd0;
    localparam logic [1:0] KindData   = 2'd1;
    localparam logic [1:0] KindCrcErr = 2'd2;
    localparam logic [1:0] KindShort  = 2'd3;

    // register indexes
    localparam logic CfgSensorLimit = 1'b0;
    localparam logic CfgTensionCap  = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic       delivery_ok;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  packet_kind;
        logic [31:0] node_id;
        logic [7:0]  sequence_res;
        logic [15:0] sensor_mv;
        logic [9:0]  tension_tenths;
        logic [15:0] battery_mv;
    } out_item_t;

    // reflected crc-8, one byte, lsb first
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CrcPoly;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/spd_tension.sv
// millivolt to tension conversion with limit and clamp
`default_nettype none

module spd_tension (
    input  wire logic [15:0] sensor_mv,
    input  wire logic [10:0] sensor_limit_mv,
    input  wire logic [9:0]  tension_cap,
    output logic      [9:0]  tension_tenths
);

    logic        over_limit;
    logic [11:0] offset_mv;
    logic [13:0] scaled;
    logic [28:0] product;
    logic [11:0] quot;
    logic [9:0]  ten_raw;

    always_comb
    begin
        over_limit = sensor_mv > {5'd0, sensor_limit_mv};
        // only used when sensor_mv fits in 11 bits
        offset_mv  = {1'b0, sensor_mv[10:0]} + spd_pkg::MvOffset;
        scaled     = {offset_mv, 2'b00};
        // divide by nine through the reciprocal, exact below 2^15
        product    = 29'(scaled) * 29'(spd_pkg::RecipNine);
        quot       = product[spd_pkg::RecipShift +: 12];
        if (over_limit || quot > {2'd0, spd_pkg::TenFull})
        begin
            ten_raw = 10'd0;
        end
        else
        begin
            ten_raw = spd_pkg::TenFull - quot[9:0];
        end
        tension_tenths = (ten_raw > tension_cap) ? tension_cap : ten_raw;
    end

endmodule

`default_nettype wire

>>> rtl/sensor_packet_decoder.sv
// Sensor packet decoder: one payload byte per transfer, one byte accepted every cycle. A byte
// sits in an input register, then the unrolled crc-8 step, the ack match and the field store
// run together, and a result is written to the output register, so a result is presented
// after its last byte has passed the input register and then the output register. Only a
// byte that yields a result while the output register still holds an untaken result waits in
// the input register; other bytes keep flowing. Bytes after the tenth are ignored; a last
// byte with delivery_ok low ends the packet without a result.
`default_nettype none
`include "sensor_packet_decoder_macros.svh"

module sensor_packet_decoder (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire spd_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output spd_pkg::out_item_t      out_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [10:0]        cfg_data
);

    spd_pkg::in_item_t  in_reg;
    logic               in_valid_reg;
    spd_pkg::out_item_t out_reg;
    spd_pkg::out_item_t out_next;
    logic               out_valid_reg;

    logic [10:0] limit_reg;
    logic [9:0]  cap_reg;

    logic [3:0]  pos_reg;
    logic [3:0]  pos_next;
    logic [7:0]  crc_reg;
    logic [7:0]  crc_next;
    logic        ack_reg;
    logic        ack_next;
    logic [7:0]  field_reg [9];

    logic [3:0]  pos0;
    logic [7:0]  crc0;
    logic        ack0;
    logic [3:0]  pos1;
    logic [7:0]  crc1;
    logic        ack1;
    logic        take;
    logic        emit_req;
    logic        in_move;
    logic [15:0] smv;
    logic [9:0]  ten;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign emit_req = in_reg.last_byte && in_reg.delivery_ok;
    assign in_move  = in_valid_reg && (!emit_req || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || in_move;

    assign smv = {field_reg[5], field_reg[6]};

    spd_tension u_tension (
        .sensor_mv       (smv),
        .sensor_limit_mv (limit_reg),
        .tension_cap     (cap_reg),
        .tension_tenths  (ten)
    );

    always_comb
    begin
        pos0 = in_reg.first_byte ? 4'd0 : pos_reg;
        crc0 = in_reg.first_byte ? 8'd0 : crc_reg;
        ack0 = in_reg.first_byte ? 1'b0 : ack_reg;
        take = pos0 < spd_pkg::PktLen;
        pos1 = pos0;
        crc1 = crc0;
        ack1 = ack0;
        if (take)
        begin
            pos1 = pos0 + 4'd1;
            crc1 = spd_pkg::crc8_update(crc0, in_reg.data_byte);
            if (pos0 == 4'd0)
            begin
                ack1 = in_reg.data_byte == spd_pkg::ChA;
            end
            else if (pos0 == 4'd1)
            begin
                ack1 = ack0 && (in_reg.data_byte == spd_pkg::ChC);
            end
            else if (pos0 == 4'd2)
            begin
                ack1 = ack0 && (in_reg.data_byte == spd_pkg::ChK);
            end
        end
        // the last byte always closes the packet
        if (in_reg.last_byte)
        begin
            pos_next = 4'd0;
            crc_next = 8'd0;
            ack_next = 1'b0;
        end
        else
        begin
            pos_next = pos1;
            crc_next = crc1;
            ack_next = ack1;
        end
    end

    always_comb
    begin
        out_next = '0;
        if (ack1 && pos1 >= spd_pkg::AckLen)
        begin
            out_next.packet_kind = spd_pkg::KindAck;
        end
        else if (pos1 < spd_pkg::PktLen)
        begin
            out_next.packet_kind = spd_pkg::KindShort;
        end
        else if (crc1 != 8'd0)
        begin
            out_next.packet_kind = spd_pkg::KindCrcErr;
        end
        else
        begin
            out_next.packet_kind    = spd_pkg::KindData;
            out_next.node_id        = {field_reg[0], field_reg[1], field_reg[2], field_reg[3]};
            out_next.sequence_res   = field_reg[4];
            out_next.sensor_mv      = smv;
            out_next.tension_tenths = ten;
            out_next.battery_mv     = {field_reg[7], field_reg[8]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= 4'd0;
            crc_reg       <= 8'd0;
            ack_reg       <= 1'b0;
            limit_reg     <= spd_pkg::LimitReset;
            cap_reg       <= spd_pkg::CapReset;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (in_move)
            begin
                pos_reg <= pos_next;
                crc_reg <= crc_next;
                ack_reg <= ack_next;
            end
            if (in_move && emit_req)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    spd_pkg::CfgSensorLimit: limit_reg <= cfg_data;
                    spd_pkg::CfgTensionCap:  cap_reg   <= cfg_data[9:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_reg <= in_data;
        end
        if (in_move && take && pos0 < spd_pkg::FieldDepth)
        begin
            field_reg[pos0] <= in_reg.data_byte;
        end
        if (in_move && emit_req)
        begin
            out_reg <= out_next;
        end
    end

    `SPD_ASSERT_IMPL(a_pos_saturates, clk, rst_n, 1'b1, pos_reg <= spd_pkg::PktLen)
    `SPD_ASSERT_IMPL(a_no_result_overrun, clk, rst_n, out_valid_reg && !out_ready,
        !(in_move && emit_req))
    `SPD_ASSERT_NEXT(a_last_clears, clk, rst_n, in_move && in_reg.last_byte,
        pos_reg == 4'd0 && crc_reg == 8'd0 && !ack_reg)
    `SPD_ASSERT_IMPL(a_nondata_zero, clk, rst_n,
        out_valid_reg && out_reg.packet_kind != spd_pkg::KindData,
        out_reg.node_id == 32'd0 && out_reg.sensor_mv == 16'd0 && out_reg.tension_tenths == 10'd0)

endmodule

`default_nettype wire
